// ===== hdl/mmu_pkg.sv =====
// Shared types, codes and constants of the matrix multiply unit.
package mmu_pkg;

   localparam int MAX_DIM_DEF    = 8;
   localparam int ELEM_WIDTH_DEF = 16;

   localparam int CMD_W     = 2;
   localparam int IDX_IN_W  = 3;
   localparam int IN_ELEM_W = 16;
   localparam int CFG_W     = 4;
   localparam int CSR_IDX_W = 2;
   localparam int PROD_W    = 36;

   typedef logic [CMD_W-1:0] cmd_type;
   localparam cmd_type CMD_LOAD_A  = 2'd0;
   localparam cmd_type CMD_LOAD_B  = 2'd1;
   localparam cmd_type CMD_COMPUTE = 2'd2;

   typedef logic [CSR_IDX_W-1:0] csr_idx_type;
   localparam csr_idx_type REG_ROWS_A     = 2'd0;
   localparam csr_idx_type REG_INNER_SIZE = 2'd1;
   localparam csr_idx_type REG_COLS_B     = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   // Control that travels down the multiply-accumulate pipe with each read.
   typedef struct packed {
      logic                valid;
      logic                first_k;
      logic                last_k;
      logic                last_elem;
      logic [IDX_IN_W-1:0] row;
      logic [IDX_IN_W-1:0] col;
   } mac_tag_type;

   // Size register as used: zero reads as one, above max_dim reads as max_dim.
   function automatic int sat_dim(input logic [CFG_W-1:0] r, input int max_dim);
      int v;
      v = int'(r);
      if (v == 0) begin
         return 1;
      end else if (v > max_dim) begin
         return max_dim;
      end
      return v;
   endfunction

endpackage

// ===== hdl/mmu_store.sv =====
// Element store: one write port, one read port with registered read data.
module mmu_store #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hdl/mmu_mac.sv =====
// Multiply-accumulate pipe: align tag with read data, multiply, accumulate, emit.
module mmu_mac #(
   parameter int ELEM_WIDTH = mmu_pkg::ELEM_WIDTH_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mmu_pkg::mac_tag_type               tag,
   input  logic signed [ELEM_WIDTH-1:0]       a_data,
   input  logic signed [ELEM_WIDTH-1:0]       b_data,
   output logic                               rsp_strobe,
   output logic [mmu_pkg::IDX_IN_W-1:0]       rsp_out_row,
   output logic [mmu_pkg::IDX_IN_W-1:0]       rsp_out_col,
   output logic signed [mmu_pkg::PROD_W-1:0]  rsp_product_value,
   output logic                               rsp_last_flag,
   output logic                               done
);
   import mmu_pkg::*;

   mac_tag_type                   tag1_ff, tag2_ff;
   logic signed [2*ELEM_WIDTH-1:0] prod_ff, prod_in;
   logic signed [PROD_W-1:0]      acc_ff, acc_in, prod_ext;
   logic                          valid_ff, valid_in;
   logic [IDX_IN_W-1:0]           row_ff, col_ff;
   logic                          last_ff;

   assign prod_in  = a_data * b_data;
   // keep the low bits of the product, sign-extended when it is narrower
   assign prod_ext = PROD_W'(prod_ff);
   assign acc_in   = tag2_ff.first_k ? prod_ext : acc_ff + prod_ext;
   assign valid_in = tag2_ff.valid & tag2_ff.last_k;

   always_ff @(posedge clock) begin
      if (reset) begin
         tag1_ff  <= '0;
         tag2_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         tag1_ff  <= tag;
         tag2_ff  <= tag1_ff;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      if (tag2_ff.valid) begin
         acc_ff <= acc_in;
      end
      row_ff  <= tag2_ff.row;
      col_ff  <= tag2_ff.col;
      last_ff <= tag2_ff.last_elem;
   end

   assign rsp_strobe        = valid_ff;
   assign rsp_out_row       = row_ff;
   assign rsp_out_col       = col_ff;
   assign rsp_product_value = acc_ff;
   assign rsp_last_flag     = last_ff;
   assign done              = valid_ff & last_ff;

endmodule

// ===== hdl/mmu_seq.sv =====
// Sequencer: walks i, j, k over the result and issues store reads.
module mmu_seq #(
   parameter int MAX_DIM = mmu_pkg::MAX_DIM_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 go,
   input  logic [$clog2(MAX_DIM+1)-1:0]         rows_dim,
   input  logic [$clog2(MAX_DIM+1)-1:0]         inner_dim,
   input  logic [$clog2(MAX_DIM+1)-1:0]         cols_dim,
   input  logic                                 done,
   output logic                                 busy,
   output logic                                 rd_en,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   a_rd_addr,
   output logic [$clog2(MAX_DIM*MAX_DIM)-1:0]   b_rd_addr,
   output mmu_pkg::mac_tag_type                 tag
);
   import mmu_pkg::*;

   localparam int DIM_W  = $clog2(MAX_DIM+1);
   localparam int IDX_W  = $clog2(MAX_DIM);
   localparam int ADDR_W = $clog2(MAX_DIM*MAX_DIM);

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] i_ff, j_ff, k_ff, i_in, j_in, k_in;
   logic             last_i, last_j, last_k;

   assign last_i = (DIM_W'(i_ff) + DIM_W'(1)) == rows_dim;
   assign last_j = (DIM_W'(j_ff) + DIM_W'(1)) == cols_dim;
   assign last_k = (DIM_W'(k_ff) + DIM_W'(1)) == inner_dim;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (go) begin
               state_in = ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (last_i && last_j && last_k) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (done) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // loop counters
   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      k_in = k_ff;
      case (state_ff)
         ST_IDLE: begin
            i_in = '0;
            j_in = '0;
            k_in = '0;
         end
         ST_ISSUE: begin
            if (!last_k) begin
               k_in = k_ff + IDX_W'(1);
            end else begin
               k_in = '0;
               if (!last_j) begin
                  j_in = j_ff + IDX_W'(1);
               end else begin
                  j_in = '0;
                  i_in = i_ff + IDX_W'(1);
               end
            end
         end
         default: ;
      endcase
   end

   // outputs
   always_comb begin
      busy          = (state_ff != ST_IDLE);
      rd_en         = (state_ff == ST_ISSUE);
      a_rd_addr     = ADDR_W'(32'(i_ff) * MAX_DIM + 32'(k_ff));
      b_rd_addr     = ADDR_W'(32'(k_ff) * MAX_DIM + 32'(j_ff));
      tag.valid     = (state_ff == ST_ISSUE);
      tag.first_k   = (k_ff == '0);
      tag.last_k    = last_k;
      tag.last_elem = last_i & last_j;
      tag.row       = IDX_IN_W'(i_ff);
      tag.col       = IDX_IN_W'(j_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

endmodule

// ===== hdl/matrix_multiply_unit.sv =====
// Top level of the matrix multiply unit: size registers, stores, sequencer, MAC pipe.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  -------------------------------
//  request   req_cmd, req_row_index, req_col_index,  taken when start=1 and busy=0
//            req_element_value
//  response  rsp_out_row, rsp_out_col,               one cycle each, rsp_strobe=1
//            rsp_product_value, rsp_last_flag
//  config    csr_wr_en, csr_index, csr_wr_data       written when csr_wr_en=1
//
// A load item (A or B element) writes its store as it is taken.
// During a compute item the sequencer issues one store read pair per cycle,
// and each result leaves after its last read through the store read, multiply
// and accumulate registers. busy stays high until the item with rsp_last_flag
// has gone out. Synchronous reset clears the size registers to 8 and idles
// the pipe; store contents are not cleared. The receiver cannot stall.
module matrix_multiply_unit #(
   parameter int MAX_DIM    = mmu_pkg::MAX_DIM_DEF,
   parameter int ELEM_WIDTH = mmu_pkg::ELEM_WIDTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [mmu_pkg::CMD_W-1:0]           req_cmd,
   input  logic [mmu_pkg::IDX_IN_W-1:0]        req_row_index,
   input  logic [mmu_pkg::IDX_IN_W-1:0]        req_col_index,
   input  logic signed [mmu_pkg::IN_ELEM_W-1:0] req_element_value,
   output logic                                rsp_strobe,
   output logic [mmu_pkg::IDX_IN_W-1:0]        rsp_out_row,
   output logic [mmu_pkg::IDX_IN_W-1:0]        rsp_out_col,
   output logic signed [mmu_pkg::PROD_W-1:0]   rsp_product_value,
   output logic                                rsp_last_flag,
   input  logic                                csr_wr_en,
   input  logic [mmu_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mmu_pkg::CFG_W-1:0]           csr_wr_data
);
   import mmu_pkg::*;

   localparam int DIM_W  = $clog2(MAX_DIM+1);
   localparam int ADDR_W = $clog2(MAX_DIM*MAX_DIM);
   localparam int DEPTH  = MAX_DIM*MAX_DIM;

   logic [CFG_W-1:0]      rows_a_ff, inner_size_ff, cols_b_ff;
   logic [DIM_W-1:0]      rows_dim, inner_dim, cols_dim;
   logic                  accept, go, done;
   logic                  a_wr_en, b_wr_en;
   logic [ADDR_W-1:0]     ld_addr, a_rd_addr, b_rd_addr;
   logic [ELEM_WIDTH-1:0] ld_value;
   logic signed [ELEM_WIDTH-1:0] a_data, b_data;
   logic                  rd_en;
   mac_tag_type           tag;

   // Size registers; an index past the list is dropped.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_a_ff     <= CFG_W'(8);
         inner_size_ff <= CFG_W'(8);
         cols_b_ff     <= CFG_W'(8);
      end else if (csr_wr_en) begin
         case (csr_index)
            REG_ROWS_A:     rows_a_ff     <= csr_wr_data;
            REG_INNER_SIZE: inner_size_ff <= csr_wr_data;
            REG_COLS_B:     cols_b_ff     <= csr_wr_data;
            default: ;
         endcase
      end
   end

   // Saturate sizes into 1..MAX_DIM.
   assign rows_dim  = DIM_W'(sat_dim(rows_a_ff, MAX_DIM));
   assign inner_dim = DIM_W'(sat_dim(inner_size_ff, MAX_DIM));
   assign cols_dim  = DIM_W'(sat_dim(cols_b_ff, MAX_DIM));

   assign accept = start & ~busy;
   assign go     = accept & (req_cmd == CMD_COMPUTE);

   // Loads only land while idle, so a write never meets a read of the same
   // entry: busy is the interlock. Drop loads outside the configured sizes.
   assign a_wr_en = accept & (req_cmd == CMD_LOAD_A)
                    & (32'(req_row_index) < 32'(rows_dim))
                    & (32'(req_col_index) < 32'(inner_dim));
   assign b_wr_en = accept & (req_cmd == CMD_LOAD_B)
                    & (32'(req_row_index) < 32'(inner_dim))
                    & (32'(req_col_index) < 32'(cols_dim));
   assign ld_addr  = ADDR_W'(32'(req_row_index) * MAX_DIM + 32'(req_col_index));
   // Resize the Q8.8 element to the store width, keeping its sign.
   assign ld_value = ELEM_WIDTH'(req_element_value);

   mmu_store #(
      .DEPTH(DEPTH),
      .WIDTH(ELEM_WIDTH)
   ) u_a_store (
      .clock  (clock),
      .wr_en  (a_wr_en),
      .wr_addr(ld_addr),
      .wr_data(ld_value),
      .rd_en  (rd_en),
      .rd_addr(a_rd_addr),
      .rd_data(a_data)
   );

   mmu_store #(
      .DEPTH(DEPTH),
      .WIDTH(ELEM_WIDTH)
   ) u_b_store (
      .clock  (clock),
      .wr_en  (b_wr_en),
      .wr_addr(ld_addr),
      .wr_data(ld_value),
      .rd_en  (rd_en),
      .rd_addr(b_rd_addr),
      .rd_data(b_data)
   );

   mmu_seq #(
      .MAX_DIM(MAX_DIM)
   ) u_seq (
      .clock    (clock),
      .reset    (reset),
      .go       (go),
      .rows_dim (rows_dim),
      .inner_dim(inner_dim),
      .cols_dim (cols_dim),
      .done     (done),
      .busy     (busy),
      .rd_en    (rd_en),
      .a_rd_addr(a_rd_addr),
      .b_rd_addr(b_rd_addr),
      .tag      (tag)
   );

   mmu_mac #(
      .ELEM_WIDTH(ELEM_WIDTH)
   ) u_mac (
      .clock            (clock),
      .reset            (reset),
      .tag              (tag),
      .a_data           (a_data),
      .b_data           (b_data),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_row      (rsp_out_row),
      .rsp_out_col      (rsp_out_col),
      .rsp_product_value(rsp_product_value),
      .rsp_last_flag    (rsp_last_flag),
      .done             (done)
   );

   // Results only come out of a running compute.
   assert property (@(posedge clock) disable iff (reset) rsp_strobe |-> busy)
      else $error("result strobe while idle");

   // The final result ends the compute.
   assert property (@(posedge clock) disable iff (reset)
                    rsp_strobe && rsp_last_flag |=> !busy)
      else $error("busy held after final result");

   // An accepted compute item starts the sequencer.
   assert property (@(posedge clock) disable iff (reset)
                    start && !busy && req_cmd == CMD_COMPUTE |=> busy)
      else $error("compute item not started");

   // Loads never touch the stores during a compute.
   assert property (@(posedge clock) disable iff (reset)
                    rd_en |-> !(a_wr_en || b_wr_en))
      else $error("store write during compute");

endmodule
